[hdl/ssdg_pkg.sv]
package ssdg_pkg;

   localparam int unsigned POS_W   = 32;
   localparam int unsigned DELAY_W = 32;

   // Request mode codes.
   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_MOVE    = 3'd1;
   localparam logic [2:0] MODE_HOME    = 3'd2;
   localparam logic [2:0] MODE_STOP    = 3'd3;
   localparam logic [2:0] MODE_ENABLE  = 3'd4;
   localparam logic [2:0] MODE_SET_POS = 3'd5;

   // Encoded motor state as reported on the response channel.
   localparam logic [1:0] MOTOR_IDLE   = 2'd0;
   localparam logic [1:0] MOTOR_MOVING = 2'd1;
   localparam logic [1:0] MOTOR_HOMING = 2'd2;

   localparam logic [DELAY_W-1:0] DEFAULT_DELAY = 32'd1000;

   // Register index decoded from paddr[2].
   localparam logic CSR_IDX_DIR_INVERT = 1'b0;

   typedef enum logic [2:0] {
      RUN_IDLE   = 3'b001,
      RUN_MOVING = 3'b010,
      RUN_HOMING = 3'b100
   } run_state_type;

   typedef struct packed {
      logic [2:0]               mode;
      logic signed [POS_W-1:0]  step_count;
      logic [DELAY_W-1:0]       step_delay;
      logic                     home_direction;
      logic                     enable_on;
      logic signed [POS_W-1:0]  new_position;
   } req_item_type;

   typedef struct packed {
      logic                     step_pulse;
      logic                     dir_level;
      logic                     enable_pin_level;
      logic [1:0]               motor_state;
      logic signed [POS_W-1:0]  position;
      logic                     move_done;
      logic                     status;
   } rsp_item_type;

endpackage

[hdl/ssdg_in_stage.sv]
module ssdg_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ssdg_pkg::req_item_type in_item,
   output logic                  in_stall,
   input  logic                  advance,
   output logic                  item_valid,
   output ssdg_pkg::req_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   logic                   accept;
   ssdg_pkg::req_item_type item_ff;

   // The held request leaves when the core advances, so a new one can enter
   // in the same cycle.
   assign in_stall = valid_ff && !advance;
   assign accept   = in_valid && !in_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/ssdg_core.sv]
module ssdg_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  ssdg_pkg::req_item_type item,
   input  logic                   dir_invert,
   output logic                   advance,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ssdg_pkg::rsp_item_type rsp_item
);

   logic [ssdg_pkg::POS_W-1:0]   cur_pos_ff, cur_pos_in;
   logic [ssdg_pkg::POS_W-1:0]   target_ff, target_in;
   logic [ssdg_pkg::DELAY_W-1:0] delay_ff, delay_in;
   logic [ssdg_pkg::DELAY_W-1:0] wait_ff, wait_in;
   ssdg_pkg::run_state_type      run_ff, run_in;
   logic                         dir_ff, dir_in;
   logic                         enabled_ff, enabled_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ssdg_pkg::rsp_item_type       rsp_ff, rsp_in;
   logic                         fire;
   logic                         pulse, done, refused;
   logic [1:0]                   motor_code;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign fire    = item_valid && advance;

   always_comb begin
      cur_pos_in = cur_pos_ff;
      target_in  = target_ff;
      delay_in   = delay_ff;
      wait_in    = wait_ff;
      run_in     = run_ff;
      dir_in     = dir_ff;
      enabled_in = enabled_ff;
      pulse      = 1'b0;
      done       = 1'b0;
      refused    = 1'b0;
      case (item.mode)
         ssdg_pkg::MODE_TICK: begin
            if (run_ff == ssdg_pkg::RUN_MOVING && cur_pos_ff == target_ff) begin
               run_in = ssdg_pkg::RUN_IDLE;
               done   = 1'b1;
            end else if (run_ff != ssdg_pkg::RUN_IDLE) begin
               if (wait_ff == '0) begin
                  pulse      = 1'b1;
                  cur_pos_in = dir_ff ? cur_pos_ff - 1'b1 : cur_pos_ff + 1'b1;
                  wait_in    = (delay_ff == '0) ? '0 : delay_ff - 1'b1;
               end else begin
                  wait_in = wait_ff - 1'b1;
               end
            end
         end
         ssdg_pkg::MODE_MOVE: begin
            if (!enabled_ff) begin
               refused = 1'b1;
            end else if (item.step_count != '0) begin
               target_in = cur_pos_ff + $unsigned(item.step_count);
               delay_in  = item.step_delay;
               run_in    = ssdg_pkg::RUN_MOVING;
               wait_in   = '0;
               dir_in    = item.step_count[ssdg_pkg::POS_W-1];
            end
         end
         ssdg_pkg::MODE_HOME: begin
            if (!enabled_ff) begin
               refused = 1'b1;
            end else begin
               dir_in   = item.home_direction;
               delay_in = item.step_delay;
               run_in   = ssdg_pkg::RUN_HOMING;
               wait_in  = '0;
            end
         end
         ssdg_pkg::MODE_STOP: begin
            target_in = cur_pos_ff;
            run_in    = ssdg_pkg::RUN_IDLE;
         end
         ssdg_pkg::MODE_ENABLE: begin
            enabled_in = item.enable_on;
            if (!item.enable_on && run_ff == ssdg_pkg::RUN_MOVING) begin
               run_in = ssdg_pkg::RUN_IDLE;
            end
         end
         ssdg_pkg::MODE_SET_POS: begin
            cur_pos_in = $unsigned(item.new_position);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (run_in)
         ssdg_pkg::RUN_MOVING: motor_code = ssdg_pkg::MOTOR_MOVING;
         ssdg_pkg::RUN_HOMING: motor_code = ssdg_pkg::MOTOR_HOMING;
         default:              motor_code = ssdg_pkg::MOTOR_IDLE;
      endcase
   end

   always_comb begin
      rsp_in.step_pulse       = pulse;
      rsp_in.dir_level        = dir_in ^ dir_invert;
      rsp_in.enable_pin_level = !enabled_in;
      rsp_in.motor_state      = motor_code;
      rsp_in.position         = $signed(cur_pos_in);
      rsp_in.move_done        = done;
      rsp_in.status           = refused;
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_pos_ff   <= '0;
         target_ff    <= '0;
         delay_ff     <= ssdg_pkg::DEFAULT_DELAY;
         wait_ff      <= '0;
         run_ff       <= ssdg_pkg::RUN_IDLE;
         dir_ff       <= 1'b0;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            cur_pos_ff <= cur_pos_in;
            target_ff  <= target_in;
            delay_ff   <= delay_in;
            wait_ff    <= wait_in;
            run_ff     <= run_in;
            dir_ff     <= dir_in;
            enabled_ff <= enabled_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[hdl/stepper_step_dir_generator.sv]
// Channel     | Direction | Handshake          | Payload
// ------------+-----------+--------------------+-----------------------------------------
// request     | in        | req_valid/req_stall| mode, step_count, step_delay, home_direction,
//             |           |                    | enable_on, new_position
// response    | out       | rsp_valid/rsp_stall| step_pulse, dir_level, enable_pin_level,
//             |           |                    | motor_state, position, move_done, status
// register    | in/out    | APB psel/penable   | dir_invert at byte address 0
//
// One request is taken every clock cycle unless the response side stalls. A request is
// held in an input register, and its response is registered in the result register; the
// single state update in the core sets the one-per-cycle rate.
// Reset is synchronous and active high: it returns the motor to idle at position zero with
// the driver disabled, a step delay of 1000 ticks and no direction inversion.
// A stalled response holds the result register; the input register then holds too and
// req_stall rises, so no request is lost while the response side waits.
module stepper_step_dir_generator (
   input  logic                                 clock,
   input  logic                                 reset,

   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_mode,
   input  logic signed [ssdg_pkg::POS_W-1:0]    req_step_count,
   input  logic [ssdg_pkg::DELAY_W-1:0]         req_step_delay,
   input  logic                                 req_home_direction,
   input  logic                                 req_enable_on,
   input  logic signed [ssdg_pkg::POS_W-1:0]    req_new_position,

   // Response channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_step_pulse,
   output logic                                 rsp_dir_level,
   output logic                                 rsp_enable_pin_level,
   output logic [1:0]                           rsp_motor_state,
   output logic signed [ssdg_pkg::POS_W-1:0]    rsp_position,
   output logic                                 rsp_move_done,
   output logic                                 rsp_status,

   // Register port.
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   ssdg_pkg::req_item_type in_item;
   ssdg_pkg::req_item_type item;
   ssdg_pkg::rsp_item_type rsp_item;
   logic                   item_valid;
   logic                   advance;
   logic                   dir_invert_ff;
   logic                   dir_invert_in;
   logic                   csr_write;

   // The register port never waits. Only paddr[2] selects a register; the low two bits
   // address bytes within the word.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      dir_invert_in = dir_invert_ff;
      if (csr_write && paddr[2] == ssdg_pkg::CSR_IDX_DIR_INVERT) begin
         dir_invert_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_invert_ff <= 1'b0;
      end else begin
         dir_invert_ff <= dir_invert_in;
      end
   end

   assign prdata = (paddr[2] == ssdg_pkg::CSR_IDX_DIR_INVERT) ? {31'd0, dir_invert_ff} : 32'd0;

   // Gather the request fields into one item.
   always_comb begin
      in_item.mode           = req_mode;
      in_item.step_count     = req_step_count;
      in_item.step_delay     = req_step_delay;
      in_item.home_direction = req_home_direction;
      in_item.enable_on      = req_enable_on;
      in_item.new_position   = req_new_position;
   end

   ssdg_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_item    (in_item),
      .in_stall   (req_stall),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ssdg_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .dir_invert (dir_invert_ff),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   assign rsp_step_pulse       = rsp_item.step_pulse;
   assign rsp_dir_level        = rsp_item.dir_level;
   assign rsp_enable_pin_level = rsp_item.enable_pin_level;
   assign rsp_motor_state      = rsp_item.motor_state;
   assign rsp_position         = rsp_item.position;
   assign rsp_move_done        = rsp_item.move_done;
   assign rsp_status           = rsp_item.status;

   // The request side may only stall while a response is waiting downstream.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a waiting response");

   // An accepted request always reaches the input register.
   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> item_valid)
      else $error("accepted request was dropped");

   // A refused command neither steps nor completes a move.
   a_refused_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (!rsp_step_pulse && !rsp_move_done))
      else $error("refused command produced motion");

   // Arrival always leaves the motor idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_move_done) |-> (rsp_motor_state == ssdg_pkg::MOTOR_IDLE))
      else $error("move completed but motor not idle");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

   // The run is bounded by this many clock cycles, a wide margin over the slowest
   // correct run of roughly 1100 requests.
   localparam int unsigned CYCLE_LIMIT        = 400000;
   localparam int unsigned RANDOM_PHASES      = 8;
   localparam int unsigned REQUESTS_PER_PHASE = 130;
   // Settling time after draining lets any stray response show up before a
   // register write or the end of the run.
   localparam int unsigned SETTLE_CYCLES      = 8;

   localparam logic [2:0] DIR_INVERT_ADDR = {ssdg_pkg::CSR_IDX_DIR_INVERT, 2'b00};
   // Mode codes the block does not use; they must leave the state untouched.
   localparam logic [2:0] MODE_SPARE_LO   = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI   = 3'd7;

   // Keeps a private copy of the motor state, works out the response of every
   // accepted request and compares the responses as they come back in order.
   class step_dir_scoreboard;
      logic [31:0]            pos;
      logic [31:0]            target;
      logic [31:0]            delay;
      logic [31:0]            wait_left;
      logic [1:0]             run;
      logic                   dir;
      logic                   enabled;
      logic                   invert;
      ssdg_pkg::rsp_item_type pending[$];
      int unsigned            mismatches;
      int unsigned            checked;
      int unsigned            steps;
      int unsigned            arrivals;
      int unsigned            refusals;

      function new();
         pos        = '0;
         target     = '0;
         delay      = ssdg_pkg::DEFAULT_DELAY;
         wait_left  = '0;
         run        = ssdg_pkg::MOTOR_IDLE;
         dir        = 1'b0;
         enabled    = 1'b0;
         invert     = 1'b0;
         mismatches = 0;
         checked    = 0;
         steps      = 0;
         arrivals   = 0;
         refusals   = 0;
      endfunction

      function void set_dir_invert(logic value);
         invert = value;
      endfunction

      function void note_request(ssdg_pkg::req_item_type r);
         ssdg_pkg::rsp_item_type e;
         e = '0;
         case (r.mode)
            ssdg_pkg::MODE_TICK: begin
               if (run == ssdg_pkg::MOTOR_MOVING && pos == target) begin
                  run         = ssdg_pkg::MOTOR_IDLE;
                  e.move_done = 1'b1;
               end else if (run == ssdg_pkg::MOTOR_MOVING || run == ssdg_pkg::MOTOR_HOMING) begin
                  if (wait_left == 0) begin
                     e.step_pulse = 1'b1;
                     pos          = dir ? pos - 32'd1 : pos + 32'd1;
                     wait_left    = (delay == 0) ? 32'd0 : delay - 32'd1;
                  end else begin
                     wait_left = wait_left - 32'd1;
                  end
               end
            end
            ssdg_pkg::MODE_MOVE: begin
               if (!enabled) begin
                  e.status = 1'b1;
               end else if (r.step_count != 0) begin
                  target    = pos + r.step_count;
                  delay     = r.step_delay;
                  run       = ssdg_pkg::MOTOR_MOVING;
                  wait_left = '0;
                  dir       = r.step_count[ssdg_pkg::POS_W-1];
               end
            end
            ssdg_pkg::MODE_HOME: begin
               if (!enabled) begin
                  e.status = 1'b1;
               end else begin
                  dir       = r.home_direction;
                  delay     = r.step_delay;
                  run       = ssdg_pkg::MOTOR_HOMING;
                  wait_left = '0;
               end
            end
            ssdg_pkg::MODE_STOP: begin
               target = pos;
               run    = ssdg_pkg::MOTOR_IDLE;
            end
            ssdg_pkg::MODE_ENABLE: begin
               enabled = r.enable_on;
               // Dropping the enable cancels a move, while homing keeps going.
               if (!r.enable_on && run == ssdg_pkg::MOTOR_MOVING) run = ssdg_pkg::MOTOR_IDLE;
            end
            ssdg_pkg::MODE_SET_POS: begin
               pos = r.new_position;
            end
            default: begin
            end
         endcase
         e.dir_level        = dir ^ invert;
         e.enable_pin_level = ~enabled;
         e.motor_state      = run;
         e.position         = pos;
         steps    += 32'(e.step_pulse);
         arrivals += 32'(e.move_done);
         refusals += 32'(e.status);
         pending.push_back(e);
      endfunction

      function void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch on %s after %0d responses: expected %0h, got %0h",
                     $time, what, checked, want, got);
      endfunction

      function void check_response(ssdg_pkg::rsp_item_type got);
         ssdg_pkg::rsp_item_type want;
         if (pending.size() == 0) begin
            report_mismatch("response with no request pending", '0, got.position);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.step_pulse !== want.step_pulse)
            report_mismatch("step_pulse", 32'(want.step_pulse), 32'(got.step_pulse));
         if (got.dir_level !== want.dir_level)
            report_mismatch("dir_level", 32'(want.dir_level), 32'(got.dir_level));
         if (got.enable_pin_level !== want.enable_pin_level)
            report_mismatch("enable_pin_level", 32'(want.enable_pin_level),
                            32'(got.enable_pin_level));
         if (got.motor_state !== want.motor_state)
            report_mismatch("motor_state", 32'(want.motor_state), 32'(got.motor_state));
         if (got.position !== want.position)
            report_mismatch("position", want.position, got.position);
         if (got.move_done !== want.move_done)
            report_mismatch("move_done", 32'(want.move_done), 32'(got.move_done));
         if (got.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(got.status));
      endfunction

      function int unsigned outstanding();
         return pending.size();
      endfunction
   endclass

   step_dir_scoreboard motion = new();

   // Every input of the block starts at a known value.
   logic                                clock              = 1'b0;
   logic                                reset              = 1'b1;
   logic                                req_valid          = 1'b0;
   logic                                req_stall;
   logic [2:0]                          req_mode           = ssdg_pkg::MODE_TICK;
   logic signed [ssdg_pkg::POS_W-1:0]   req_step_count     = '0;
   logic [ssdg_pkg::DELAY_W-1:0]        req_step_delay     = '0;
   logic                                req_home_direction = 1'b0;
   logic                                req_enable_on      = 1'b0;
   logic signed [ssdg_pkg::POS_W-1:0]   req_new_position   = '0;
   logic                                rsp_valid;
   logic                                rsp_stall          = 1'b0;
   logic                                rsp_step_pulse;
   logic                                rsp_dir_level;
   logic                                rsp_enable_pin_level;
   logic [1:0]                          rsp_motor_state;
   logic signed [ssdg_pkg::POS_W-1:0]   rsp_position;
   logic                                rsp_move_done;
   logic                                rsp_status;
   logic                                psel               = 1'b0;
   logic                                penable            = 1'b0;
   logic                                pwrite             = 1'b0;
   logic [2:0]                          paddr              = '0;
   logic [31:0]                         pwdata             = '0;
   logic [31:0]                         prdata;
   logic                                pready;

   // Largest idle gap each side may draw per request or response; zero gives
   // stretches where both sides run flat out.
   int unsigned req_gap_max   = 10;
   int unsigned rsp_stall_max = 10;
   int unsigned requests_sent = 0;
   int unsigned cycle_count   = 0;

   stepper_step_dir_generator dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_step_count       (req_step_count),
      .req_step_delay       (req_step_delay),
      .req_home_direction   (req_home_direction),
      .req_enable_on        (req_enable_on),
      .req_new_position     (req_new_position),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_step_pulse       (rsp_step_pulse),
      .rsp_dir_level        (rsp_dir_level),
      .rsp_enable_pin_level (rsp_enable_pin_level),
      .rsp_motor_state      (rsp_motor_state),
      .rsp_position         (rsp_position),
      .rsp_move_done        (rsp_move_done),
      .rsp_status           (rsp_status),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d responses still pending",
               cycle_count, motion.outstanding());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Response side. Before each response it draws a stall length, holds
   // rsp_stall high for that many cycles and then takes the next response.
   // All signals are sampled right after the rising edge, before any of the
   // edge's nonblocking updates land, so they hold their pre-edge values.
   initial begin
      int unsigned            hold;
      ssdg_pkg::rsp_item_type got;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = (rsp_stall_max == 0) ? 0 : $urandom_range(0, rsp_stall_max);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.step_pulse       = rsp_step_pulse;
         got.dir_level        = rsp_dir_level;
         got.enable_pin_level = rsp_enable_pin_level;
         got.motor_state      = rsp_motor_state;
         got.position         = rsp_position;
         got.move_done        = rsp_move_done;
         got.status           = rsp_status;
         motion.check_response(got);
      end
   end

   // Offers one request after a random gap and returns at the edge where it
   // is accepted. When the gap is zero, valid simply stays high, so valid
   // never gets two assignments in the same time step.
   task automatic send_request(input ssdg_pkg::req_item_type item);
      int unsigned gap;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= item.mode;
      req_step_count     <= item.step_count;
      req_step_delay     <= item.step_delay;
      req_home_direction <= item.home_direction;
      req_enable_on      <= item.enable_on;
      req_new_position   <= item.new_position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      motion.note_request(item);
      if (item.mode <= ssdg_pkg::MODE_SET_POS) requests_sent++;
   endtask

   // Every field gets random content, so fields a mode ignores still toggle.
   function automatic ssdg_pkg::req_item_type random_request(logic [2:0] mode);
      ssdg_pkg::req_item_type item;
      item.mode           = mode;
      item.step_count     = $urandom;
      item.step_delay     = $urandom;
      item.home_direction = 1'($urandom_range(0, 1));
      item.enable_on      = 1'($urandom_range(0, 1));
      item.new_position   = $urandom;
      return item;
   endfunction

   task automatic send_ticks(input int unsigned n);
      repeat (n) send_request(random_request(ssdg_pkg::MODE_TICK));
   endtask

   task automatic send_move(input logic [31:0] count, input logic [31:0] delay);
      ssdg_pkg::req_item_type item;
      item            = random_request(ssdg_pkg::MODE_MOVE);
      item.step_count = count;
      item.step_delay = delay;
      send_request(item);
   endtask

   task automatic send_home(input logic direction, input logic [31:0] delay);
      ssdg_pkg::req_item_type item;
      item                = random_request(ssdg_pkg::MODE_HOME);
      item.home_direction = direction;
      item.step_delay     = delay;
      send_request(item);
   endtask

   task automatic send_enable(input logic on);
      ssdg_pkg::req_item_type item;
      item           = random_request(ssdg_pkg::MODE_ENABLE);
      item.enable_on = on;
      send_request(item);
   endtask

   task automatic send_position(input logic [31:0] value);
      ssdg_pkg::req_item_type item;
      item              = random_request(ssdg_pkg::MODE_SET_POS);
      item.new_position = value;
      send_request(item);
   endtask

   // Holds the request side until every expected response is back, then lets
   // the block settle. Register writes only happen after this.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (motion.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write with a setup and an access cycle, then a read-back.
   task automatic write_dir_invert(input logic value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= DIR_INVERT_ADDR;
      pwdata  <= {31'($urandom_range(0, 32'h7fff_ffff)), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      motion.set_dir_invert(value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[0] !== value)
         motion.report_mismatch("dir_invert read-back", 32'(value), prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // One short well-formed sequence, or a bit of noise. Moves and homing get
   // enough ticks to step and, for moves, usually to arrive.
   task automatic random_sequence();
      int unsigned            pick;
      int unsigned            n;
      int                     count;
      logic [31:0]            delay;
      ssdg_pkg::req_item_type item;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // Mostly enabling, so that moves are not refused all the time.
         send_enable($urandom_range(0, 3) != 0);
      end else if (pick < 14) begin
         send_request(random_request(3'($urandom_range(0, 7))));
      end else if (pick < 20) begin
         case ($urandom_range(0, 3))
            0:       send_position(32'h7fff_ffff - $urandom_range(0, 3));
            1:       send_position(32'h8000_0000 + $urandom_range(0, 3));
            2:       send_position(32'hffff_ffff - $urandom_range(0, 3) + 32'd2);
            default: send_position($urandom);
         endcase
      end else if (pick < 62) begin
         if ($urandom_range(0, 19) == 0) begin
            // Huge counts or delays: the move will not finish here.
            send_move($urandom, $urandom);
            n = $urandom_range(1, 6);
         end else begin
            count = int'($urandom_range(0, 12)) - 6;
            delay = $urandom_range(0, 3);
            send_move(count, delay);
            n = ((count < 0) ? -count : count) * (delay + 1) + 1 + $urandom_range(0, 2);
            if (n > 40) n = 40;
         end
         // Now and then a command lands in the middle of the move.
         repeat (n) begin
            if ($urandom_range(0, 24) == 0)
               send_request(random_request(3'($urandom_range(1, 5))));
            else send_request(random_request(ssdg_pkg::MODE_TICK));
         end
      end else if (pick < 82) begin
         delay = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2);
         send_home(1'($urandom_range(0, 1)), delay);
         send_ticks($urandom_range(3, 12));
         if ($urandom_range(0, 9) != 0) send_request(random_request(ssdg_pkg::MODE_STOP));
      end else begin
         send_ticks($urandom_range(1, 8));
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned phase_start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_dir_invert(1'b0);

      // Directed part. Moves and homing are refused while the driver is disabled,
      // the spare mode codes do nothing, and a zero-length move is ignored.
      send_ticks(1);
      send_move(32'd5, 32'd0);
      send_home(1'b0, 32'd0);
      send_request(random_request(MODE_SPARE_LO));
      send_request(random_request(MODE_SPARE_HI));
      send_enable(1'b1);
      send_move(32'd0, 32'd0);
      // Zero delay: a step on every tick, then arrival on the tick after.
      send_move(32'd2, 32'd0);
      send_ticks(3);
      // The position wraps from the largest positive to the most negative value.
      send_position(32'h7fff_ffff);
      send_move(32'd1, 32'd1);
      send_ticks(2);
      // Loading the position during a downward move makes it arrive at once.
      send_move(-32'sd3, 32'd0);
      send_ticks(1);
      send_position(32'h7fff_fffd);
      send_ticks(1);
      // Homing survives a disable and only ends with a stop.
      send_home(1'b1, 32'hffff_ffff);
      send_ticks(2);
      send_enable(1'b0);
      send_ticks(1);
      send_request(random_request(ssdg_pkg::MODE_STOP));
      // Extreme counts, then disabling cancels the move.
      send_enable(1'b1);
      send_move(32'h7fff_ffff, 32'hffff_ffff);
      send_ticks(1);
      send_move(32'h8000_0000, 32'd2);
      send_enable(1'b0);
      drain();

      // Random part. Each phase runs with its own direction inversion and its
      // own idling profile, including phases where neither side ever idles.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_dir_invert((phase < 2) ? !phase[0] : 1'($urandom_range(0, 1)));
         case (phase)
            0: begin req_gap_max = 10; rsp_stall_max = 10; end
            1: begin req_gap_max = 0;  rsp_stall_max = 0;  end
            2: begin req_gap_max = 10; rsp_stall_max = 0;  end
            3: begin req_gap_max = 0;  rsp_stall_max = 10; end
            default: begin
               req_gap_max   = $urandom_range(0, 1) * 10;
               rsp_stall_max = $urandom_range(0, 1) * 10;
            end
         endcase
         phase_start = requests_sent;
         while (requests_sent - phase_start < REQUESTS_PER_PHASE) random_sequence();
         drain();
      end

      $display("Ran %0d requests over %0d random phases with the direction output %s",
               requests_sent, RANDOM_PHASES, "both plain and inverted.");
      $display("The motor took %0d steps, finished %0d moves and refused %0d commands.",
               motion.steps, motion.arrivals, motion.refusals);
      if (motion.mismatches == 0 && motion.outstanding() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d responses missing",
                  motion.mismatches, motion.outstanding());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
